// ===== hdl/dssm_pkg.sv =====
// Shared types, sizes and codes for the dual stack shared memory core.
package dssm_pkg;

    // Memory size and derived widths.
    localparam int DEPTH   = 128;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int FILL_W  = $clog2(DEPTH + 1);
    localparam int WORD_W  = 32;
    localparam int COUNT_W = 8;

    // Requested action, carried on the input tuser.
    typedef enum logic [1:0] {
        ACT_PUSH_LEFT  = 2'd0,
        ACT_PUSH_RIGHT = 2'd1,
        ACT_POP_LEFT   = 2'd2,
        ACT_POP_RIGHT  = 2'd3
    } action_t;

    // Result status, carried on the output tuser.
    localparam logic [1:0] STAT_DONE  = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    // Command from the controller to the datapath.
    typedef struct packed {
        logic exec;   // Execute the accepted action this cycle.
    } dssm_cmd_t;

endpackage

// ===== hdl/dual_stack_shared_memory_core.sv =====
// Top level of the dual stack shared memory core.
//
// Two stacks share one memory of DEPTH 32-bit words: the left stack grows up
// from entry 0 and the right stack grows down from the last entry.
// Input channel s_*: one beat asks for one action, given on s_tuser
// (push left, push right, pop left, pop right); s_tdata holds the word to push.
// Output channel m_*: one result beat per input beat, carrying the popped word
// and both fill counts on m_tdata and the status on m_tuser.
// A push into a full memory is refused with the full status, and a pop from an
// empty side with the empty status; refused actions change nothing.
// The result is valid in the cycle after the input beat, once the memory's
// registered read port has returned the popped word.
// One action is handled at a time: after the input beat no new input beat is
// taken until the result beat is accepted, after which s_tready rises again.
// If the receiver stalls, the result holds on m_tdata and m_tuser and no new
// input beat is taken until it is accepted.
// Reset clears both fill counts and the handshake state; the memory keeps
// undefined contents, which are never read before they are written.
module dual_stack_shared_memory_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // push_value[31:0]
    input  logic [7:0]  s_tuser,   // action[1:0], zeros[7:2]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // pop_value[31:0], left_count[39:32], right_count[47:40]
    output logic [7:0]  m_tuser    // status[1:0], zeros[7:2]
);
    import dssm_pkg::*;

    dssm_cmd_t          cmd;
    action_t            action;
    logic [WORD_W-1:0]  pop_value;
    logic [1:0]         status;
    logic [COUNT_W-1:0] left_count;
    logic [COUNT_W-1:0] right_count;

    assign action = action_t'(s_tuser[1:0]);

    // Handshake controller.
    dssm_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // Memory and counters.
    dssm_datapath u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .action      (action),
        .push_value  (s_tdata),
        .pop_value   (pop_value),
        .status      (status),
        .left_count  (left_count),
        .right_count (right_count)
    );

    // Pack the result beat.
    assign m_tdata = {right_count, left_count, pop_value};
    assign m_tuser = {6'd0, status};

endmodule

// ===== hdl/dssm_ctrl.sv =====
// Handshake controller: accepts one beat, then presents its result.
module dssm_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    output dssm_pkg::dssm_cmd_t cmd
);
    import dssm_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_RESP
    } state_t;

    state_t state_reg, state_next;
    logic   s_tready_reg, s_tready_next;
    logic   m_tvalid_reg, m_tvalid_next;

    // Next state: wait for an input beat, then hold the result until taken.
    always_comb
    begin
        state_next    = state_reg;
        s_tready_next = s_tready_reg;
        m_tvalid_next = m_tvalid_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next    = ST_RESP;
                    s_tready_next = 1'b0;
                    m_tvalid_next = 1'b1;
                end
            end
            ST_RESP:
            begin
                if (m_tready)
                begin
                    state_next    = ST_IDLE;
                    s_tready_next = 1'b1;
                    m_tvalid_next = 1'b0;
                end
            end
            default:
            begin
                state_next    = ST_IDLE;
                s_tready_next = 1'b1;
                m_tvalid_next = 1'b0;
            end
        endcase
    end

    // State and registered handshake outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            s_tready_reg <= 1'b1;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            s_tready_reg <= s_tready_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = s_tready_reg;
    assign m_tvalid = m_tvalid_reg;
    assign cmd.exec = s_tvalid && s_tready_reg;

endmodule

// ===== hdl/dssm_datapath.sv =====
// Datapath: shared word memory, both fill counters and the result register.
module dssm_datapath
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  dssm_pkg::dssm_cmd_t          cmd,
    input  dssm_pkg::action_t            action,
    input  logic signed [dssm_pkg::WORD_W-1:0]  push_value,
    output logic signed [dssm_pkg::WORD_W-1:0]  pop_value,
    output logic [1:0]                   status,
    output logic [dssm_pkg::COUNT_W-1:0] left_count,
    output logic [dssm_pkg::COUNT_W-1:0] right_count
);
    import dssm_pkg::*;

    logic [WORD_W-1:0] mem [DEPTH];

    logic [FILL_W-1:0] left_fill_reg, left_fill_next;
    logic [FILL_W-1:0] right_fill_reg, right_fill_next;
    logic [1:0]        status_reg, status_next;
    logic              pop_ok_reg, pop_ok_next;
    logic [WORD_W-1:0] rd_data_reg;

    logic [FILL_W:0]   total;
    logic              full;
    logic              wr_en;
    logic              rd_en;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] top_addr;

    // Both stacks together are full when their fills reach the depth.
    assign total    = {1'b0, left_fill_reg} + {1'b0, right_fill_reg};
    assign full     = (total >= (FILL_W + 1)'(DEPTH));
    assign top_addr = ADDR_W'(DEPTH - 1);

    // Decide the action's outcome and the memory address it touches.
    always_comb
    begin
        left_fill_next  = left_fill_reg;
        right_fill_next = right_fill_reg;
        status_next     = STAT_DONE;
        pop_ok_next     = 1'b0;
        wr_en           = 1'b0;
        rd_en           = 1'b0;
        addr            = '0;
        unique case (action)
            ACT_PUSH_LEFT:
            begin
                addr = left_fill_reg[ADDR_W-1:0];
                if (full)
                begin
                    status_next = STAT_FULL;
                end
                else
                begin
                    wr_en          = 1'b1;
                    left_fill_next = left_fill_reg + 1'b1;
                end
            end
            ACT_PUSH_RIGHT:
            begin
                addr = top_addr - right_fill_reg[ADDR_W-1:0];
                if (full)
                begin
                    status_next = STAT_FULL;
                end
                else
                begin
                    wr_en           = 1'b1;
                    right_fill_next = right_fill_reg + 1'b1;
                end
            end
            ACT_POP_LEFT:
            begin
                addr = left_fill_reg[ADDR_W-1:0] - 1'b1;
                if (left_fill_reg == '0)
                begin
                    status_next = STAT_EMPTY;
                end
                else
                begin
                    rd_en          = 1'b1;
                    pop_ok_next    = 1'b1;
                    left_fill_next = left_fill_reg - 1'b1;
                end
            end
            ACT_POP_RIGHT:
            begin
                addr = top_addr - (right_fill_reg[ADDR_W-1:0] - 1'b1);
                if (right_fill_reg == '0)
                begin
                    status_next = STAT_EMPTY;
                end
                else
                begin
                    rd_en           = 1'b1;
                    pop_ok_next     = 1'b1;
                    right_fill_next = right_fill_reg - 1'b1;
                end
            end
            default:
            begin
                status_next = STAT_DONE;
            end
        endcase
    end

    // Fill counters and result status.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_fill_reg  <= '0;
            right_fill_reg <= '0;
            status_reg     <= STAT_DONE;
            pop_ok_reg     <= 1'b0;
        end
        else if (cmd.exec)
        begin
            left_fill_reg  <= left_fill_next;
            right_fill_reg <= right_fill_next;
            status_reg     <= status_next;
            pop_ok_reg     <= pop_ok_next;
        end
    end

    // Shared memory with a registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.exec && wr_en)
        begin
            mem[addr] <= push_value;
        end
        if (cmd.exec && rd_en)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    // Result fields; a refused action or a push reports zero data.
    assign pop_value   = pop_ok_reg ? rd_data_reg : '0;
    assign status      = status_reg;
    assign left_count  = COUNT_W'(left_fill_reg);
    assign right_count = COUNT_W'(right_fill_reg);

endmodule

// ===== hdl/dssm_checker.sv =====
// Port-level checks for the dual stack shared memory core, bound to the top.
module dssm_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic [7:0]  m_tuser
);
    import dssm_pkg::*;

    // A stalled result beat keeps its payload.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // Every accepted input beat gives a result in the next cycle.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("result missing one cycle after input beat");

    // Only one action is in flight at a time.
    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready)
        else $error("input taken while a result is pending");

    // A refused action reports zero data.
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1:0] != STAT_DONE |-> m_tdata[31:0] == 32'd0)
        else $error("refused action reports nonzero data");

    // The status of a valid result is always one of the defined codes.
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser[1:0] == STAT_DONE || m_tuser[1:0] == STAT_FULL
                      || m_tuser[1:0] == STAT_EMPTY))
        else $error("undefined status code");

endmodule

bind dual_stack_shared_memory_core dssm_checker u_dssm_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
